>>> rtl/infix_integer_expression_evaluator_core_defines.svh
// Assertion macros for the infix expression evaluator.
// No dependencies; expects clk and rst_n in the including module.
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evaluator check failed");
// next-cycle implication
`define IIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evaluator check failed");
`else
`define IIE_ASSERT_IMP(lbl, ante, cons)
`define IIE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/iie_pkg.sv
// Shared types, character codes and helpers for the expression evaluator.
// No dependencies; used by the mul/div unit and the top level.
package iie_pkg;

  localparam int VALUE_WIDTH = 32;               // arithmetic wraps at this width
  localparam int MD_ADD_W    = VALUE_WIDTH + 2;  // shared adder, with borrow bit
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam int         RADIX    = 10;

  typedef enum logic [1:0] {
    TOP_NONE = 2'd0,
    TOP_MUL  = 2'd1,
    TOP_DIV  = 2'd2
  } term_op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CHAR = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } stat_t;

  // what to do once the operand is folded in
  typedef enum logic [1:0] {
    ACT_SUM,
    ACT_PROD,
    ACT_END
  } act_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_OPND,
    SQ_WAIT,
    SQ_CLOSE,
    SQ_FIN
  } seq_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_ABSA,
    MD_ABSB,
    MD_RUN,
    MD_FIX
  } md_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_rsp_t;

  // sign-extend or truncate a working value onto the 32-bit result field
  function automatic logic signed [31:0] to_out32(input logic [VALUE_WIDTH-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[31:0];
  endfunction

endpackage

>>> rtl/iie_if.sv
// Valid/ready channel interfaces for the evaluator's input and result words.
// No dependencies; the field widths are written out here as literals.
interface iie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface iie_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

>>> rtl/iie_muldiv.sv
// Iterative multiply / truncating signed divide around one shared adder.
// Depends on iie_pkg for widths, states and the request/response structs.
module iie_muldiv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  iie_pkg::md_req_t                  req,
  input  logic [iie_pkg::VALUE_WIDTH-1:0]   opa_in,
  input  logic [iie_pkg::VALUE_WIDTH-1:0]   opb_in,
  output iie_pkg::md_rsp_t                  rsp,
  output logic [iie_pkg::VALUE_WIDTH-1:0]   result
);

  iie_pkg::md_state_t state_r, state_nxt;
  logic [iie_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [iie_pkg::VALUE_WIDTH-1:0] acc_r, acc_nxt;   // product / remainder / result
  logic [iie_pkg::VALUE_WIDTH-1:0] opa_r, opa_nxt;   // multiplicand / dividend-quotient
  logic [iie_pkg::VALUE_WIDTH-1:0] opb_r, opb_nxt;   // multiplier / divisor
  logic is_div_r, is_div_nxt;
  logic neg_r, neg_nxt;
  logic done_r, done_nxt;

  logic [iie_pkg::MD_ADD_W-1:0] add_x, add_y, add_sum;
  logic                         add_sub;

  assign add_sum = add_x + (add_y ^ {iie_pkg::MD_ADD_W{add_sub}})
                 + iie_pkg::MD_ADD_W'(add_sub);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iie_pkg::MD_IDLE: begin
        if (req.start) begin
          state_nxt = req.is_div ? iie_pkg::MD_ABSA : iie_pkg::MD_RUN;
        end
      end
      iie_pkg::MD_ABSA: state_nxt = iie_pkg::MD_ABSB;
      iie_pkg::MD_ABSB: state_nxt = iie_pkg::MD_RUN;
      iie_pkg::MD_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = is_div_r ? iie_pkg::MD_FIX : iie_pkg::MD_IDLE;
        end
      end
      iie_pkg::MD_FIX:  state_nxt = iie_pkg::MD_IDLE;
      default:          state_nxt = iie_pkg::MD_IDLE;
    endcase
  end

  // datapath and adder steering
  always_comb begin
    acc_nxt    = acc_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    cnt_nxt    = cnt_r;
    is_div_nxt = is_div_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    add_x      = '0;
    add_y      = '0;
    add_sub    = 1'b0;
    unique case (state_r)
      iie_pkg::MD_IDLE: begin
        if (req.start) begin
          acc_nxt    = '0;
          opa_nxt    = opa_in;
          opb_nxt    = opb_in;
          is_div_nxt = req.is_div;
          neg_nxt    = opa_in[iie_pkg::VALUE_WIDTH-1] ^ opb_in[iie_pkg::VALUE_WIDTH-1];
          cnt_nxt    = iie_pkg::CNT_W'(iie_pkg::VALUE_WIDTH - 1);
        end
      end
      iie_pkg::MD_ABSA: begin
        add_y   = iie_pkg::MD_ADD_W'(opa_r);
        add_sub = 1'b1;
        if (opa_r[iie_pkg::VALUE_WIDTH-1]) begin
          opa_nxt = add_sum[iie_pkg::VALUE_WIDTH-1:0];
        end
      end
      iie_pkg::MD_ABSB: begin
        add_y   = iie_pkg::MD_ADD_W'(opb_r);
        add_sub = 1'b1;
        if (opb_r[iie_pkg::VALUE_WIDTH-1]) begin
          opb_nxt = add_sum[iie_pkg::VALUE_WIDTH-1:0];
        end
      end
      iie_pkg::MD_RUN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (is_div_r) begin
          // restoring step: trial subtract of the divisor from the shifted remainder
          add_x   = iie_pkg::MD_ADD_W'({acc_r, opa_r[iie_pkg::VALUE_WIDTH-1]});
          add_y   = iie_pkg::MD_ADD_W'(opb_r);
          add_sub = 1'b1;
          if (!add_sum[iie_pkg::MD_ADD_W-1]) begin
            acc_nxt = add_sum[iie_pkg::VALUE_WIDTH-1:0];
            opa_nxt = {opa_r[iie_pkg::VALUE_WIDTH-2:0], 1'b1};
          end else begin
            acc_nxt = add_x[iie_pkg::VALUE_WIDTH-1:0];
            opa_nxt = {opa_r[iie_pkg::VALUE_WIDTH-2:0], 1'b0};
          end
        end else begin
          add_x   = iie_pkg::MD_ADD_W'(acc_r);
          add_y   = opb_r[0] ? iie_pkg::MD_ADD_W'(opa_r) : '0;
          acc_nxt = add_sum[iie_pkg::VALUE_WIDTH-1:0];
          opa_nxt = opa_r << 1;
          opb_nxt = opb_r >> 1;
          if (cnt_r == '0) begin
            done_nxt = 1'b1;
          end
        end
      end
      iie_pkg::MD_FIX: begin
        // apply the quotient sign
        add_y    = iie_pkg::MD_ADD_W'(opa_r);
        add_sub  = neg_r;
        acc_nxt  = add_sum[iie_pkg::VALUE_WIDTH-1:0];
        done_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iie_pkg::MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    cnt_r    <= cnt_nxt;
    is_div_r <= is_div_nxt;
    neg_r    <= neg_nxt;
  end

  assign rsp.busy = (state_r != iie_pkg::MD_IDLE);
  assign rsp.done = done_r;
  assign result   = acc_r;

endmodule

>>> rtl/infix_integer_expression_evaluator_core.sv
// Streaming infix integer evaluator: one ASCII character per input word, + - * / with
// precedence, one result word on the end-of-expression word.
// Depends on iie_pkg, iie_if, iie_muldiv and the assertion macro header.
//
// Usage: feed one character per input word; the word flagged end_of_expr closes the
// expression (its character is ignored) and yields one result word of value and status
// (ok, invalid character, division by zero; invalid character wins, value 0 on error).
// Spaces, digits and invalid characters are taken while idle. An operator passes the
// operand and close states, waiting in between on the shared mul/div unit when * is
// pending, or / with a non-zero divisor; that unit runs a one-bit-a-cycle loop. The end
// word goes the same way and then through the final state, which loads the output
// register once it is free. Input ready is low while an item is being worked on; a
// result left waiting in the output register only holds back the next end word. No
// clearing pass is needed after reset.
`include "infix_integer_expression_evaluator_core_defines.svh"

module infix_integer_expression_evaluator_core (
  input  logic         clk,
  input  logic         rst_n,
  iie_in_if.sink       in_ch,
  iie_out_if.source    out_ch
);

  // sequencer and expression state
  iie_pkg::seq_state_t state_r, state_nxt;
  iie_pkg::act_t       act_r, act_nxt;
  logic                alt_r, alt_nxt;       // '-' for a sum step, '/' for a product step
  logic [iie_pkg::VALUE_WIDTH-1:0] lit_r, lit_nxt;
  logic [iie_pkg::VALUE_WIDTH-1:0] term_r, term_nxt;
  iie_pkg::term_op_t   term_op_r, term_op_nxt;
  logic [iie_pkg::VALUE_WIDTH-1:0] sum_r, sum_nxt;
  logic                sign_neg_r, sign_neg_nxt;
  logic                bad_r, bad_nxt;
  logic                dz_r, dz_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic signed [31:0]  out_value_r, out_value_nxt;
  iie_pkg::stat_t      out_status_r, out_status_nxt;

  // mul/div unit
  iie_pkg::md_req_t                md_req;
  iie_pkg::md_rsp_t                md_rsp;
  logic [iie_pkg::VALUE_WIDTH-1:0] md_res;

  logic in_acc, out_free;
  logic is_space, is_digit, is_pm, is_md;
  logic [iie_pkg::VALUE_WIDTH-1:0] lit_dig;
  logic [iie_pkg::VALUE_WIDTH-1:0] sum_upd;

  assign in_ch.ready = (state_r == iie_pkg::SQ_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // character classes
  assign is_space = (in_ch.char_code == iie_pkg::CH_SPACE);
  assign is_digit = (in_ch.char_code >= iie_pkg::CH_0) && (in_ch.char_code <= iie_pkg::CH_9);
  assign is_pm    = (in_ch.char_code == iie_pkg::CH_PLUS) ||
                    (in_ch.char_code == iie_pkg::CH_MINUS);
  assign is_md    = (in_ch.char_code == iie_pkg::CH_STAR) ||
                    (in_ch.char_code == iie_pkg::CH_SLASH);

  // lit * 10 + digit, the multiply as two shifts
  assign lit_dig = (lit_r << 3) + (lit_r << 1)
                 + iie_pkg::VALUE_WIDTH'(in_ch.char_code - iie_pkg::CH_0);

  // running sum +/- term, one adder with conditional invert
  assign sum_upd = sum_r + (term_r ^ {iie_pkg::VALUE_WIDTH{sign_neg_r}})
                 + iie_pkg::VALUE_WIDTH'(sign_neg_r);

  // unit request: a pending * always, a pending / only with a non-zero divisor
  assign md_req.start  = (state_r == iie_pkg::SQ_OPND) &&
                         ((term_op_r == iie_pkg::TOP_MUL) ||
                          ((term_op_r == iie_pkg::TOP_DIV) && (lit_r != '0)));
  assign md_req.is_div = (term_op_r == iie_pkg::TOP_DIV);

  iie_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .opa_in (term_r),
    .opb_in (lit_r),
    .rsp    (md_rsp),
    .result (md_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iie_pkg::SQ_IDLE: begin
        if (in_acc && (in_ch.end_of_expr || is_pm || is_md)) begin
          state_nxt = iie_pkg::SQ_OPND;
        end
      end
      iie_pkg::SQ_OPND: begin
        state_nxt = md_req.start ? iie_pkg::SQ_WAIT : iie_pkg::SQ_CLOSE;
      end
      iie_pkg::SQ_WAIT: begin
        if (md_rsp.done) begin
          state_nxt = iie_pkg::SQ_CLOSE;
        end
      end
      iie_pkg::SQ_CLOSE: begin
        state_nxt = (act_r == iie_pkg::ACT_END) ? iie_pkg::SQ_FIN : iie_pkg::SQ_IDLE;
      end
      iie_pkg::SQ_FIN: begin
        if (out_free) begin
          state_nxt = iie_pkg::SQ_IDLE;
        end
      end
      default: state_nxt = iie_pkg::SQ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_nxt        = act_r;
    alt_nxt        = alt_r;
    lit_nxt        = lit_r;
    term_nxt       = term_r;
    term_op_nxt    = term_op_r;
    sum_nxt        = sum_r;
    sign_neg_nxt   = sign_neg_r;
    bad_nxt        = bad_r;
    dz_nxt         = dz_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      iie_pkg::SQ_IDLE: begin
        if (in_acc) begin
          if (in_ch.end_of_expr) begin
            act_nxt = iie_pkg::ACT_END;
          end else if (is_digit) begin
            lit_nxt = lit_dig;
          end else if (is_pm) begin
            act_nxt = iie_pkg::ACT_SUM;
            alt_nxt = (in_ch.char_code == iie_pkg::CH_MINUS);
          end else if (is_md) begin
            act_nxt = iie_pkg::ACT_PROD;
            alt_nxt = (in_ch.char_code == iie_pkg::CH_SLASH);
          end else if (!is_space) begin
            bad_nxt = 1'b1;
          end
        end
      end
      iie_pkg::SQ_OPND: begin
        // fold the operand into the term; the unit latches lit_r on this edge
        lit_nxt = '0;
        unique case (term_op_r)
          iie_pkg::TOP_MUL: begin
          end
          iie_pkg::TOP_DIV: begin
            if (lit_r == '0) begin
              dz_nxt = 1'b1;        // term left as it was
            end
          end
          default: term_nxt = lit_r;
        endcase
      end
      iie_pkg::SQ_WAIT: begin
        if (md_rsp.done) begin
          term_nxt = md_res;
        end
      end
      iie_pkg::SQ_CLOSE: begin
        case (act_r)
          iie_pkg::ACT_PROD: begin
            term_op_nxt = alt_r ? iie_pkg::TOP_DIV : iie_pkg::TOP_MUL;
          end
          iie_pkg::ACT_SUM: begin
            sum_nxt      = sum_upd;
            term_nxt     = '0;
            term_op_nxt  = iie_pkg::TOP_NONE;
            sign_neg_nxt = alt_r;
          end
          default: begin
            sum_nxt     = sum_upd;
            term_nxt    = '0;
            term_op_nxt = iie_pkg::TOP_NONE;
          end
        endcase
      end
      iie_pkg::SQ_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            out_status_nxt = iie_pkg::STAT_BAD_CHAR;
            out_value_nxt  = '0;
          end else if (dz_r) begin
            out_status_nxt = iie_pkg::STAT_DIV_ZERO;
            out_value_nxt  = '0;
          end else begin
            out_status_nxt = iie_pkg::STAT_OK;
            out_value_nxt  = iie_pkg::to_out32(sum_r);
          end
          // fresh expression
          lit_nxt      = '0;
          term_nxt     = '0;
          term_op_nxt  = iie_pkg::TOP_NONE;
          sum_nxt      = '0;
          sign_neg_nxt = 1'b0;
          bad_nxt      = 1'b0;
          dz_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iie_pkg::SQ_IDLE;
      lit_r       <= '0;
      term_r      <= '0;
      term_op_r   <= iie_pkg::TOP_NONE;
      sum_r       <= '0;
      sign_neg_r  <= 1'b0;
      bad_r       <= 1'b0;
      dz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lit_r       <= lit_nxt;
      term_r      <= term_nxt;
      term_op_r   <= term_op_nxt;
      sum_r       <= sum_nxt;
      sign_neg_r  <= sign_neg_nxt;
      bad_r       <= bad_nxt;
      dz_r        <= dz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    alt_r        <= alt_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  // checks
  `IIE_ASSERT_IMP(a_out_from_fin, $rose(out_valid_r), $past(state_r) == iie_pkg::SQ_FIN)
  `IIE_ASSERT_IMP(a_busy_in_wait, md_rsp.busy, state_r == iie_pkg::SQ_WAIT)
  `IIE_ASSERT_IMP(a_done_in_wait, md_rsp.done, state_r == iie_pkg::SQ_WAIT)
  `IIE_ASSERT_IMP(a_no_div_zero, md_req.start && md_req.is_div, lit_r != '0)
  `IIE_ASSERT_NXT(a_start_to_wait, md_req.start, state_r == iie_pkg::SQ_WAIT)

endmodule
